>>> hw/rtl/strided_conv2d_mac_top_defines.svh
// Assertion macros shared by the conv MAC block.
`ifndef STRIDED_CONV2D_MAC_TOP_DEFINES_SVH
`define STRIDED_CONV2D_MAC_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge out of reset.
`define SCM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scm: same-cycle check failed");

// Next-cycle implication.
`define SCM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scm: next-cycle check failed");

`endif

>>> hw/rtl/scm_pkg.sv
`default_nettype none

package scm_pkg;

    localparam int MAX_IN_CH  = 4;
    localparam int MAX_OUT_CH = 64;
    localparam int MAX_KERNEL = 16;
    localparam int MAX_IMAGE  = 64;

    // Index widths into the stores
    localparam int IC_W  = (MAX_IN_CH  > 1) ? $clog2(MAX_IN_CH)  : 1;
    localparam int OC_W  = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
    localparam int K_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int IMG_W = $clog2(MAX_IMAGE);

    // Widths that hold a count up to the maximum itself
    localparam int ICNT_W   = $clog2(MAX_IN_CH + 1);
    localparam int KCNT_W   = $clog2(MAX_KERNEL + 1);
    localparam int IMGCNT_W = $clog2(MAX_IMAGE + 1);

    localparam int WEIGHT_DEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
    localparam int IMAGE_DEPTH  = MAX_IN_CH * MAX_IMAGE * MAX_IMAGE;
    localparam int WADDR_W = OC_W + IC_W + 2 * K_W;
    localparam int IADDR_W = IC_W + 2 * IMG_W;

    localparam int DATA_W  = 16;
    localparam int FRAC_W  = 12;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int ACC_W   = 48;
    localparam int RES_W   = 32;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IN_CHANNELS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_ROWS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_COLS   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BIAS_ENABLE   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd7;

    // Function codes
    localparam logic [1:0] FUNC_WEIGHT  = 2'd0;
    localparam logic [1:0] FUNC_BIAS    = 2'd1;
    localparam logic [1:0] FUNC_PIXEL   = 2'd2;
    localparam logic [1:0] FUNC_COMPUTE = 2'd3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_SAT     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } scm_state_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [5:0]        out_chan;
        logic [1:0]        in_chan;
        logic [5:0]        row;
        logic [5:0]        col;
        logic signed [15:0] value;
    } scm_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
    } scm_out_t;

    typedef struct packed {
        logic [2:0] in_channels;
        logic [4:0] kernel_height;
        logic [4:0] kernel_width;
        logic [4:0] stride_rows;
        logic [4:0] stride_cols;
        logic       bias_enable;
        logic [6:0] image_height;
        logic [6:0] image_width;
    } scm_cfg_t;

    // One issued read: valid, first and last element of the sum, or a
    // rejected window that needs an immediate answer
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic reject;
    } scm_tag_t;

    localparam scm_cfg_t CFG_RESET = '{
        in_channels:   3'd3,
        kernel_height: 5'd16,
        kernel_width:  5'd16,
        stride_rows:   5'd16,
        stride_cols:   5'd16,
        bias_enable:   1'b1,
        image_height:  7'd64,
        image_width:   7'd64
    };

    function automatic logic [9:0] clamp_cfg(input logic [9:0] v, input logic [9:0] hi);
        logic [9:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = 10'd1;
            end
            else if (v > hi)
            begin
                r = hi;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/scm_ram.sv
`default_nettype none

module scm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/scm_agu.sv
`default_nettype none

module scm_agu
    import scm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire scm_in_t           cmd,
    input  wire scm_cfg_t          cfg,
    input  wire logic              done,
    output logic                   busy,
    output scm_tag_t               tag,
    output logic [WADDR_W-1:0]     waddr,
    output logic [IADDR_W-1:0]     iaddr,
    output logic [OC_W-1:0]        baddr
);

    localparam int ORG_W = 6 + 5;
    localparam int END_W = ORG_W + 1;

    scm_state_t state_reg, state_next;

    logic [IC_W-1:0]  c_reg, c_next;
    logic [K_W-1:0]   r_reg, r_next;
    logic [K_W-1:0]   k_reg, k_next;

    logic [OC_W-1:0]  oc_reg;
    logic [IMG_W-1:0] r0_reg, c0_reg;
    logic [IC_W-1:0]  nc_m1_reg;
    logic [K_W-1:0]   kh_m1_reg, kw_m1_reg;

    logic [ICNT_W-1:0]   nc_c;
    logic [KCNT_W-1:0]   kh_c, kw_c;
    logic [IMGCNT_W-1:0] ih_c, iw_c;
    logic [4:0]          sr, sc;
    logic [ORG_W-1:0]    r0_full, c0_full;
    logic [END_W-1:0]    r_end, c_end;
    logic                accept, compute, outside, engage, at_last;

    assign nc_c = ICNT_W'(clamp_cfg(10'(cfg.in_channels), 10'(MAX_IN_CH)));
    assign kh_c = KCNT_W'(clamp_cfg(10'(cfg.kernel_height), 10'(MAX_KERNEL)));
    assign kw_c = KCNT_W'(clamp_cfg(10'(cfg.kernel_width), 10'(MAX_KERNEL)));
    assign ih_c = IMGCNT_W'(clamp_cfg(10'(cfg.image_height), 10'(MAX_IMAGE)));
    assign iw_c = IMGCNT_W'(clamp_cfg(10'(cfg.image_width), 10'(MAX_IMAGE)));
    assign sr   = (cfg.stride_rows == '0) ? 5'd1 : cfg.stride_rows;
    assign sc   = (cfg.stride_cols == '0) ? 5'd1 : cfg.stride_cols;

    assign r0_full = ORG_W'(cmd.row) * ORG_W'(sr);
    assign c0_full = ORG_W'(cmd.col) * ORG_W'(sc);
    assign r_end   = END_W'(r0_full) + END_W'(kh_c);
    assign c_end   = END_W'(c0_full) + END_W'(kw_c);

    assign accept  = start && !busy;
    assign compute = accept && (cmd.func == FUNC_COMPUTE);
    assign outside = (32'(cmd.out_chan) >= MAX_OUT_CH)
                  || (r_end > END_W'(ih_c)) || (c_end > END_W'(iw_c));
    assign engage  = compute && !outside;

    assign at_last = (k_reg == kw_m1_reg) && (r_reg == kh_m1_reg) && (c_reg == nc_m1_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (engage)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (at_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy       = 1'b1;
        tag        = '0;
        tag.reject = compute && outside;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
            end
            S_RUN:
            begin
                tag.valid = 1'b1;
                tag.first = (c_reg == '0) && (r_reg == '0) && (k_reg == '0);
                tag.last  = at_last;
            end
            S_WAIT:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // Walk kernel columns, then rows, then input channels
    always_comb
    begin
        c_next = c_reg;
        r_next = r_reg;
        k_next = k_reg;
        if (state_reg == S_RUN)
        begin
            if (k_reg == kw_m1_reg)
            begin
                k_next = '0;
                if (r_reg == kh_m1_reg)
                begin
                    r_next = '0;
                    c_next = c_reg + 1'b1;
                end
                else
                begin
                    r_next = r_reg + 1'b1;
                end
            end
            else
            begin
                k_next = k_reg + 1'b1;
            end
        end
        else
        begin
            c_next = '0;
            r_next = '0;
            k_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            c_reg     <= '0;
            r_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            c_reg     <= c_next;
            r_reg     <= r_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (engage)
        begin
            oc_reg    <= OC_W'(cmd.out_chan);
            r0_reg    <= IMG_W'(r0_full);
            c0_reg    <= IMG_W'(c0_full);
            nc_m1_reg <= IC_W'(nc_c - 1'b1);
            kh_m1_reg <= K_W'(kh_c - 1'b1);
            kw_m1_reg <= K_W'(kw_c - 1'b1);
        end
    end

    assign waddr = {oc_reg, c_reg, r_reg, k_reg};
    assign iaddr = {c_reg, IMG_W'(r0_reg + IMG_W'(r_reg)), IMG_W'(c0_reg + IMG_W'(k_reg))};
    assign baddr = oc_reg;

endmodule

`default_nettype wire

>>> hw/rtl/scm_mac.sv
`default_nettype none

module scm_mac
    import scm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire scm_tag_t            tag,
    input  wire logic [DATA_W-1:0]   wdata,
    input  wire logic [DATA_W-1:0]   idata,
    input  wire logic [DATA_W-1:0]   bdata,
    input  wire logic                bias_enable,
    output logic                     done,
    output scm_out_t                 result
);

    localparam int Q_W = ACC_W - FRAC_W;

    scm_tag_t t1_reg, t2_reg, t3_reg;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [DATA_W-1:0] bias_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next, base;
    logic signed [Q_W-1:0]    q;
    logic                     fits;
    logic                     done_reg, done_next;
    scm_out_t                 result_reg, result_next;

    assign prod_next = $signed(wdata) * $signed(idata);

    assign base = bias_enable ? (ACC_W'(bias_reg) <<< FRAC_W) : '0;

    always_comb
    begin
        acc_next = acc_reg;
        if (t2_reg.valid)
        begin
            acc_next = (t2_reg.first ? base : acc_reg) + ACC_W'(prod_reg);
        end
    end

    // Floor shift is a plain arithmetic shift; clamp when the top bits disagree
    assign q    = acc_reg[ACC_W-1:FRAC_W];
    assign fits = (&q[Q_W-1:RES_W-1]) || !(|q[Q_W-1:RES_W-1]);

    always_comb
    begin
        done_next   = 1'b0;
        result_next = result_reg;
        if (t3_reg.valid && t3_reg.last)
        begin
            done_next = 1'b1;
            if (fits)
            begin
                result_next.result_value = q[RES_W-1:0];
                result_next.status       = ST_OK;
            end
            else
            begin
                result_next.result_value = q[Q_W-1] ? {1'b1, {(RES_W-1){1'b0}}}
                                                    : {1'b0, {(RES_W-1){1'b1}}};
                result_next.status       = ST_SAT;
            end
        end
        else if (tag.reject)
        begin
            done_next                = 1'b1;
            result_next.result_value = '0;
            result_next.status       = ST_OUTSIDE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg   <= '0;
            t2_reg   <= '0;
            t3_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            t1_reg   <= tag;
            t2_reg   <= t1_reg;
            t3_reg   <= t2_reg;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        bias_reg   <= $signed(bdata);
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> hw/rtl/strided_conv2d_mac_top.sv
`default_nettype none
// Strided multi-channel 2D convolution, one output point per compute word.
//
// Input: a word is taken on a rising edge with start high and busy low.
// func selects a weight, bias or pixel write, or a compute of one output.
// Writes land in the stores in the cycle of acceptance and produce no result;
// the next word can follow in the next cycle.
// A compute word whose window lies past the configured image (or whose output
// channel is out of range) answers on the next cycle with status outside and
// a zero value, without raising busy.
// A valid compute walks N = in_channels * kernel_height * kernel_width
// products, one weight and one pixel read per cycle from single-port-read
// stores. The result strobe (done) follows the last product through the store
// read, product, accumulator and result registers; busy drops in the cycle
// after done. result holds its value until the next result; no back pressure.
// Configuration must be written through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block does not enforce this. Reset restores register
// defaults; the stores keep whatever they held and must be written before use.

module strided_conv2d_mac_top
    import scm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire scm_in_t                cmd,
    output logic                        busy,
    output logic                        done,
    output scm_out_t                    result,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

`include "strided_conv2d_mac_top_defines.svh"

    scm_cfg_t cfg_reg, cfg_next;

    scm_tag_t           tag;
    logic [WADDR_W-1:0] w_raddr, w_waddr;
    logic [IADDR_W-1:0] i_raddr, i_waddr;
    logic [OC_W-1:0]    b_raddr;
    logic [DATA_W-1:0]  w_rdata, i_rdata, b_rdata;
    logic               accept, w_we, b_we, i_we;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IN_CHANNELS:   cfg_next.in_channels   = cfg_data[2:0];
                REG_KERNEL_HEIGHT: cfg_next.kernel_height = cfg_data[4:0];
                REG_KERNEL_WIDTH:  cfg_next.kernel_width  = cfg_data[4:0];
                REG_STRIDE_ROWS:   cfg_next.stride_rows   = cfg_data[4:0];
                REG_STRIDE_COLS:   cfg_next.stride_cols   = cfg_data[4:0];
                REG_BIAS_ENABLE:   cfg_next.bias_enable   = cfg_data[0];
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_data[6:0];
                REG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_data[6:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Store writes; drop any beyond the store bounds
    assign accept = start && !busy;
    assign w_we   = accept && (cmd.func == FUNC_WEIGHT)
                 && (32'(cmd.out_chan) < MAX_OUT_CH) && (32'(cmd.in_chan) < MAX_IN_CH)
                 && (32'(cmd.row) < MAX_KERNEL) && (32'(cmd.col) < MAX_KERNEL);
    assign b_we   = accept && (cmd.func == FUNC_BIAS) && (32'(cmd.out_chan) < MAX_OUT_CH);
    assign i_we   = accept && (cmd.func == FUNC_PIXEL) && (32'(cmd.in_chan) < MAX_IN_CH)
                 && (32'(cmd.row) < MAX_IMAGE) && (32'(cmd.col) < MAX_IMAGE);

    assign w_waddr = {OC_W'(cmd.out_chan), IC_W'(cmd.in_chan), K_W'(cmd.row), K_W'(cmd.col)};
    assign i_waddr = {IC_W'(cmd.in_chan), IMG_W'(cmd.row), IMG_W'(cmd.col)};

    scm_agu u_agu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .cfg   (cfg_reg),
        .done  (done),
        .busy  (busy),
        .tag   (tag),
        .waddr (w_raddr),
        .iaddr (i_raddr),
        .baddr (b_raddr)
    );

    scm_ram #(.WIDTH(DATA_W), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (cmd.value),
        .re    (tag.valid),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    scm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_OUT_CH)) u_bias_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (OC_W'(cmd.out_chan)),
        .wdata (cmd.value),
        .re    (tag.valid),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    scm_ram #(.WIDTH(DATA_W), .DEPTH(IMAGE_DEPTH)) u_image_ram (
        .clk   (clk),
        .we    (i_we),
        .waddr (i_waddr),
        .wdata (cmd.value),
        .re    (tag.valid),
        .raddr (i_raddr),
        .rdata (i_rdata)
    );

    scm_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .tag         (tag),
        .wdata       (w_rdata),
        .idata       (i_rdata),
        .bdata       (b_rdata),
        .bias_enable (cfg_reg.bias_enable),
        .done        (done),
        .result      (result)
    );

    `SCM_ASSERT_NEXT(a_compute_engages, accept && cmd.func == FUNC_COMPUTE, busy || done)
    `SCM_ASSERT_NEXT(a_result_frees, busy && done, !busy)
    `SCM_ASSERT_SAME(a_outside_zero, done && result.status == ST_OUTSIDE, result.result_value == '0)

endmodule

`default_nettype wire
